// ===== rtl/core/base64_stream_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_assert.svh
// Assertion macros used by the base64 stream decoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define B64_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, constants and the alphabet lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64sd_pkg;

  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharReturn  = 8'h0D;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharDigit0  = 8'h30;
  localparam logic [5:0] SextetLower = 6'd26;
  localparam logic [5:0] SextetDigit = 6'd52;
  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;

  // Burst queue depth (entries).
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  // One input's worth of results: up to three bytes of a group word,
  // or an empty end marker when nbytes is zero and done is set.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        done;
  } burst_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t s;
    logic [7:0] diff;
    s = '0;
    diff = '0;
    case (ch) inside
      [8'h41:8'h5A]: begin
        diff = ch - CharUpperA;
        s = '{valid: 1'b1, value: diff[5:0]};
      end
      [8'h61:8'h7A]: begin
        diff = ch - CharLowerA;
        s = '{valid: 1'b1, value: diff[5:0] + SextetLower};
      end
      [8'h30:8'h39]: begin
        diff = ch - CharDigit0;
        s = '{valid: 1'b1, value: diff[5:0] + SextetDigit};
      end
      8'h2B:   s = '{valid: 1'b1, value: SextetPlus};
      8'h2F:   s = '{valid: 1'b1, value: SextetSlash};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64sd_stream_if.sv =====
// ----------------------------------------------------------------------------
// b64sd_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface b64sd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/base64_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: one character word in, decoded byte words out.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                    Word accepted when
// in_ch    in   char_code, end_of_text                     valid && ready
// out_ch   out  out_byte, byte_valid, run_last, text_done  valid && ready
//
// A character is taken every cycle while the two-entry burst queue has room.
// Decode and group update finish in the accept cycle; results leave from the
// queue at one byte per cycle while out_ch is ready; a burst holds its entry
// until its last byte is taken; input stalls only when both entries are full.
// Reset clears the group and the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder (
  input  wire logic         clk,
  input  wire logic         rst,
  b64sd_stream_if.sink      in_ch,
  b64sd_stream_if.source    out_ch
);

  // Group state
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  slots_filled, slots_filled_next;
  logic [1:0]  valid_slots, valid_slots_next;

  // Burst queue
  b64sd_pkg::burst_t queue [b64sd_pkg::QueueDepth];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fifo_count;
  logic [1:0]  byte_idx;

  b64sd_pkg::in_item_t in_item;
  b64sd_pkg::sextet_t  sx;
  b64sd_pkg::burst_t   head, burst_new;
  logic        skip, full, in_fire, out_fire, push, pop;
  logic [23:0] word_new;
  logic [2:0]  filled_cnt, valid_cnt;
  logic [1:0]  nbytes_new, head_results, head_last_idx;
  logic [5:0]  ins_value;

  assign in_item  = in_ch.payload;
  assign in_ch.ready = (fifo_count != 2'd2);
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Decode and fold into the group
  always_comb begin
    skip = in_item.char_code inside {b64sd_pkg::CharNewline, b64sd_pkg::CharReturn,
                                     b64sd_pkg::CharSpace};
    sx = b64sd_pkg::sextet_of(in_item.char_code);
    ins_value = skip ? 6'd0 : sx.value;
    word_new = group_bits;
    case (slots_filled)
      2'd0:    word_new[23:18] = group_bits[23:18] | ins_value;
      2'd1:    word_new[17:12] = group_bits[17:12] | ins_value;
      2'd2:    word_new[11:6]  = group_bits[11:6]  | ins_value;
      2'd3:    word_new[5:0]   = group_bits[5:0]   | ins_value;
      default: word_new = group_bits;
    endcase
    filled_cnt = {1'b0, slots_filled} + {2'b00, !skip};
    valid_cnt  = {1'b0, valid_slots} + {2'b00, (!skip && sx.valid)};
    full = (filled_cnt == 3'd4);
    nbytes_new = (valid_cnt >= 3'd2) ? 2'(valid_cnt - 3'd1) : 2'd0;
    // a completed group emits; a partial group emits only at end of text
    if (!full && !in_item.end_of_text) begin
      nbytes_new = 2'd0;
    end else if (!full && filled_cnt == 3'd0) begin
      nbytes_new = 2'd0;
    end
    burst_new = '{word: word_new, nbytes: nbytes_new, done: in_item.end_of_text};
    if (full || in_item.end_of_text) begin
      group_bits_next   = '0;
      slots_filled_next = '0;
      valid_slots_next  = '0;
    end else begin
      group_bits_next   = word_new;
      slots_filled_next = filled_cnt[1:0];
      valid_slots_next  = valid_cnt[1:0];
    end
  end

  assign push = in_fire && ((nbytes_new != 2'd0) || in_item.end_of_text);

  // Serialize the head burst
  always_comb begin
    head = queue[rd_ptr];
    head_results  = (head.nbytes == 2'd0) ? 2'd1 : head.nbytes;
    head_last_idx = head_results - 2'd1;
    out_ch.valid  = (fifo_count != 2'd0);
    out_ch.payload.byte_valid = (head.nbytes != 2'd0);
    out_ch.payload.run_last   = (byte_idx == head_last_idx);
    out_ch.payload.text_done  = head.done && (byte_idx == head_last_idx);
    case (byte_idx)
      2'd0:    out_ch.payload.out_byte = head.word[23:16];
      2'd1:    out_ch.payload.out_byte = head.word[15:8];
      2'd2:    out_ch.payload.out_byte = head.word[7:0];
      default: out_ch.payload.out_byte = '0;
    endcase
    if (head.nbytes == 2'd0) begin
      out_ch.payload.out_byte = '0;
    end
  end

  assign out_fire = out_ch.valid && out_ch.ready;
  assign pop      = out_fire && out_ch.payload.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits   <= '0;
      slots_filled <= '0;
      valid_slots  <= '0;
      wr_ptr       <= 1'b0;
      rd_ptr       <= 1'b0;
      fifo_count   <= '0;
      byte_idx     <= '0;
    end else begin
      if (in_fire) begin
        group_bits   <= group_bits_next;
        slots_filled <= slots_filled_next;
        valid_slots  <= valid_slots_next;
      end
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr   <= !rd_ptr;
        byte_idx <= '0;
      end else if (out_fire) begin
        byte_idx <= byte_idx + 2'd1;
      end
      fifo_count <= fifo_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= burst_new;
    end
  end

`include "base64_stream_decoder_assert.svh"

  `B64_ASSERT_NOW(a_queue_bound, 1'b1, fifo_count <= 2'd2, "burst queue overflow")
  `B64_ASSERT_NOW(a_idx_in_burst, out_ch.valid, byte_idx <= head_last_idx,
                  "byte index past end of burst")
  `B64_ASSERT_NOW(a_empty_marker, out_ch.valid && !out_ch.payload.byte_valid,
                  out_ch.payload.run_last && out_ch.payload.text_done,
                  "empty result that does not end the text")
  `B64_ASSERT_NEXT(a_count_up, push && !pop, fifo_count == $past(fifo_count) + 2'd1,
                   "queue count did not follow a push")

endmodule

`default_nettype wire
